/* sv/bdd_node_store_engine_assert.svh */
// assertion macros for the bdd node store engine
// expects clk and rst in the scope of each use
`ifndef BDD_NODE_STORE_ENGINE_ASSERT_SVH
`define BDD_NODE_STORE_ENGINE_ASSERT_SVH
`ifndef SYNTHESIS
`define BNSE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BNSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BNSE_ASSERT_IMPL(lbl, ante, cons)
`define BNSE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* sv/bnse_pkg.sv */
// shared types and codes of the bdd node store engine
// no dependencies
`default_nettype none
package bnse_pkg;
  localparam int ID_W = 10;
  localparam int LEVEL_W = 6;
  localparam int ASSIGN_W = 64;
  localparam int FIRST_INTERIOR = 2;

  localparam logic [1:0] OP_MAKE  = 2'd0;
  localparam logic [1:0] OP_EVAL  = 2'd1;
  localparam logic [1:0] OP_COUNT = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_UNALLOC = 2'd2;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [ID_W-1:0]    low;
    logic [ID_W-1:0]    high;
  } node_t;
endpackage
`default_nettype wire

/* sv/bnse_ram.sv */
// generic single write port ram with one registered read port
// no dependencies
`default_nettype none
module bnse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

/* sv/bdd_node_store_engine.sv */
// top level of the bdd node store engine: control sequencer and node/mark memories
// depends on bnse_pkg, bnse_ram and bdd_node_store_engine_assert.svh
`include "bdd_node_store_engine_assert.svh"
`default_nettype none
// Reduced ordered BDD unique table. Ids 0 and 1 are the terminals, interior
// nodes are appended from id 2. One operation is in flight at a time; the next
// transaction is taken as soon as the sequencer is back in idle, even while the
// previous result waits on the output. Each operation is paced by the single
// read port of the node memory: make node scans the stored interior nodes with a
// read and a compare per node, evaluate walks the path with a read and a step per
// node, and count live runs a mark clearing pass and then sweeps the interior
// nodes from the highest id down, marking the children of each live node.
module bdd_node_store_engine
  import bnse_pkg::*;
#(
  parameter int MAX_NODES  = 1024,
  parameter int MAX_LEVELS = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output      logic         s_tready,
  // var_level[5:0], low_child[15:6], high_child[25:16], root_id[35:26],
  // assignment[99:36], zero pad
  input  wire logic [103:0] s_tdata,
  // opcode[1:0]
  input  wire logic [1:0]   s_tuser,
  output      logic         m_tvalid,
  input  wire logic         m_tready,
  // node_id[9:0], value[10], live_count[20:11], zero pad
  output      logic [23:0]  m_tdata,
  // status[1:0]
  output      logic [1:0]   m_tuser
);
  localparam int AW = $clog2(MAX_NODES);
  localparam int CW = $clog2(MAX_NODES + 1);
  localparam int EW = (CW > ID_W) ? CW : ID_W;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MK_RD   = 4'd1;
  localparam logic [3:0] S_MK_CMP  = 4'd2;
  localparam logic [3:0] S_EV_RD   = 4'd3;
  localparam logic [3:0] S_EV_STEP = 4'd4;
  localparam logic [3:0] S_CL_CLR  = 4'd5;
  localparam logic [3:0] S_CL_RD   = 4'd6;
  localparam logic [3:0] S_CL_CHK  = 4'd7;
  localparam logic [3:0] S_CL_HI   = 4'd8;
  localparam logic [3:0] S_DONE    = 4'd9;

  logic [3:0]          state;
  logic [CW-1:0]       count;
  logic [CW-1:0]       idx;
  logic [CW-1:0]       steps;
  logic [CW-1:0]       live;
  logic [LEVEL_W-1:0]  lvl;
  logic [ID_W-1:0]     lo;
  logic [ID_W-1:0]     hi;
  logic [ID_W-1:0]     cur;
  logic [ASSIGN_W-1:0] assign_bits;
  logic [ID_W-1:0]     r_id;
  logic                r_val;
  logic [1:0]          r_st;

  logic          node_we, node_re, mark_we, mark_re, mark_wdata, mark_rdata;
  logic [AW-1:0] node_raddr, mark_waddr, mark_raddr;
  node_t         node_wdata, node_rdata;

  logic [LEVEL_W-1:0]  in_lvl;
  logic [ID_W-1:0]     in_lo, in_hi, in_root;
  logic [ASSIGN_W-1:0] in_assign;
  logic                in_acc, out_load;
  logic                idx_lt_cnt, cnt_full, cur_interior, idx_interior, eval_go, lvl_bit;

  assign in_lvl    = s_tdata[5:0];
  assign in_lo     = s_tdata[15:6];
  assign in_hi     = s_tdata[25:16];
  assign in_root   = s_tdata[35:26];
  assign in_assign = s_tdata[99:36];

  assign s_tready = (state == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  assign idx_lt_cnt   = idx < count;
  assign cnt_full     = count == CW'(MAX_NODES);
  assign cur_interior = cur >= ID_W'(FIRST_INTERIOR);
  assign idx_interior = idx >= CW'(FIRST_INTERIOR);
  assign eval_go      = cur_interior && (steps < CW'(MAX_NODES));
  assign lvl_bit      = (7'(node_rdata.level) < 7'(MAX_LEVELS)) ?
                        assign_bits[node_rdata.level] : 1'b0;

  // node memory ports
  assign node_re = ((state == S_MK_RD) && idx_lt_cnt) || ((state == S_EV_RD) && eval_go) ||
                   ((state == S_CL_RD) && idx_interior);
  assign node_raddr = (state == S_EV_RD) ? AW'(cur) : AW'(idx);
  assign node_we    = (state == S_MK_RD) && !idx_lt_cnt && !cnt_full;
  assign node_wdata = '{level: lvl, low: lo, high: hi};

  // mark memory ports
  assign mark_re    = (state == S_CL_RD) && idx_interior;
  assign mark_raddr = AW'(idx);

  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = AW'(idx);
    mark_wdata = 1'b0;
    unique case (state)
      S_CL_CLR: begin
        if (idx_lt_cnt) begin
          mark_we = 1'b1;
        end else if (cur_interior) begin
          mark_we    = 1'b1;
          mark_waddr = AW'(cur);
          mark_wdata = 1'b1;
        end
      end
      S_CL_CHK: begin
        mark_we    = mark_rdata && (node_rdata.low >= ID_W'(FIRST_INTERIOR));
        mark_waddr = AW'(node_rdata.low);
        mark_wdata = 1'b1;
      end
      S_CL_HI: begin
        mark_we    = node_rdata.high >= ID_W'(FIRST_INTERIOR);
        mark_waddr = AW'(node_rdata.high);
        mark_wdata = 1'b1;
      end
      default: begin
      end
    endcase
  end

  bnse_ram #(.WIDTH($bits(node_t)), .DEPTH(MAX_NODES)) u_node_ram (
    .clk  (clk),
    .we   (node_we),
    .waddr(AW'(count)),
    .wdata(node_wdata),
    .re   (node_re),
    .raddr(node_raddr),
    .rdata(node_rdata)
  );

  bnse_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_mark_ram (
    .clk  (clk),
    .we   (mark_we),
    .waddr(mark_waddr),
    .wdata(mark_wdata),
    .re   (mark_re),
    .raddr(mark_raddr),
    .rdata(mark_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= CW'(FIRST_INTERIOR);
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {3'b000, ID_W'(live), r_val, r_id};
        m_tuser  <= r_st;
        state    <= S_IDLE;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            lvl         <= in_lvl;
            lo          <= in_lo;
            hi          <= in_hi;
            cur         <= in_root;
            assign_bits <= in_assign;
            r_id        <= '0;
            r_val       <= 1'b0;
            r_st        <= ST_OK;
            live        <= '0;
            steps       <= '0;
            idx         <= CW'(FIRST_INTERIOR);
            state       <= S_DONE;
            unique case (s_tuser)
              OP_MAKE: begin
                if (EW'(in_lo) >= EW'(count) || EW'(in_hi) >= EW'(count)) begin
                  r_st <= ST_UNALLOC;
                end else if (in_lo == in_hi) begin
                  r_id <= in_lo;
                end else begin
                  state <= S_MK_RD;
                end
              end
              OP_EVAL, OP_COUNT: begin
                if (EW'(in_root) >= EW'(count)) begin
                  r_st <= ST_UNALLOC;
                end else begin
                  state <= (s_tuser == OP_EVAL) ? S_EV_RD : S_CL_CLR;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_MK_RD: begin
          if (idx_lt_cnt) begin
            state <= S_MK_CMP;
          end else if (cnt_full) begin
            r_st  <= ST_FULL;
            state <= S_DONE;
          end else begin
            r_id  <= ID_W'(count);
            count <= count + CW'(1);
            state <= S_DONE;
          end
        end
        S_MK_CMP: begin
          if (node_rdata.level == lvl && node_rdata.low == lo && node_rdata.high == hi) begin
            r_id  <= ID_W'(idx);
            state <= S_DONE;
          end else begin
            idx   <= idx + CW'(1);
            state <= S_MK_RD;
          end
        end
        S_EV_RD: begin
          if (eval_go) begin
            state <= S_EV_STEP;
          end else begin
            r_id  <= cur;
            r_val <= (cur == ID_W'(1));
            state <= S_DONE;
          end
        end
        S_EV_STEP: begin
          cur   <= lvl_bit ? node_rdata.high : node_rdata.low;
          steps <= steps + CW'(1);
          state <= S_EV_RD;
        end
        S_CL_CLR: begin
          if (idx_lt_cnt) begin
            idx <= idx + CW'(1);
          end else begin
            idx   <= count - CW'(1);
            state <= S_CL_RD;
          end
        end
        S_CL_RD: begin
          state <= idx_interior ? S_CL_CHK : S_DONE;
        end
        S_CL_CHK: begin
          if (mark_rdata) begin
            live  <= live + CW'(1);
            state <= S_CL_HI;
          end else begin
            idx   <= idx - CW'(1);
            state <= S_CL_RD;
          end
        end
        S_CL_HI: begin
          idx   <= idx - CW'(1);
          state <= S_CL_RD;
        end
        S_DONE: begin
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `BNSE_ASSERT_IMPL(a_count_range, 1'b1, count >= CW'(FIRST_INTERIOR) && count <= CW'(MAX_NODES))
  `BNSE_ASSERT_IMPL(a_append_room, node_we, !cnt_full)
  `BNSE_ASSERT_NEXT(a_accept_busy, in_acc, state != S_IDLE)
  `BNSE_ASSERT_IMPL(a_mark_interior, mark_we && mark_wdata,
                    mark_waddr >= AW'(FIRST_INTERIOR))
endmodule
`default_nettype wire

/* tb/sv/bdd_node_store_engine_tb.sv */
// testbench for the bdd node store engine: random and directed make/evaluate/count and unused opcode traffic
// depends on bnse_pkg and bdd_node_store_engine; a scoreboard class holds the node store model
`default_nettype none
module bdd_node_store_engine_tb;
  import bnse_pkg::*;

  localparam int NODES = 1024;
  localparam int WDOG_LIMIT = 200000;

  typedef struct packed {
    logic [9:0] node_id;
    logic       value;
    logic [9:0] live_count;
    logic [1:0] status;
  } bdd_result_t;

  class bdd_scoreboard;
    logic [5:0] lvl_mem [NODES];
    logic [9:0] lo_mem [NODES];
    logic [9:0] hi_mem [NODES];
    int unsigned used;
    bdd_result_t pending [$];
    int errors;

    function new();
      used = FIRST_INTERIOR;
      errors = 0;
    endfunction

    function bdd_result_t run_make(logic [5:0] lv, logic [9:0] lo, logic [9:0] hi);
      bdd_result_t r;
      r = '0;
      if (lo >= used || hi >= used) begin
        r.status = ST_UNALLOC;
        return r;
      end
      if (lo == hi) begin
        r.node_id = lo;
        return r;
      end
      for (int i = FIRST_INTERIOR; i < used; i++)
        if (lvl_mem[i] == lv && lo_mem[i] == lo && hi_mem[i] == hi) begin
          r.node_id = 10'(i);
          return r;
        end
      if (used >= NODES) begin
        r.status = ST_FULL;
        return r;
      end
      lvl_mem[used] = lv;
      lo_mem[used] = lo;
      hi_mem[used] = hi;
      r.node_id = 10'(used);
      used++;
      return r;
    endfunction

    function bdd_result_t run_eval(logic [9:0] root, logic [63:0] asg);
      bdd_result_t r;
      int unsigned cur;
      int steps;
      r = '0;
      if (root >= used) begin
        r.status = ST_UNALLOC;
        return r;
      end
      cur = root;
      steps = 0;
      while (cur >= FIRST_INTERIOR && steps < NODES) begin
        cur = asg[lvl_mem[cur]] ? hi_mem[cur] : lo_mem[cur];
        steps++;
      end
      r.node_id = 10'(cur);
      r.value = (cur == 1);
      return r;
    endfunction

    function bdd_result_t run_count(logic [9:0] root);
      bdd_result_t r;
      bit marks [NODES];
      int cnt;
      r = '0;
      if (root >= used) begin
        r.status = ST_UNALLOC;
        return r;
      end
      foreach (marks[i]) marks[i] = 0;
      if (root >= FIRST_INTERIOR) marks[root] = 1;
      cnt = 0;
      for (int n = int'(used) - 1; n >= FIRST_INTERIOR; n--) begin
        if (!marks[n]) continue;
        cnt++;
        if (lo_mem[n] >= FIRST_INTERIOR) marks[lo_mem[n]] = 1;
        if (hi_mem[n] >= FIRST_INTERIOR) marks[hi_mem[n]] = 1;
      end
      r.live_count = 10'(cnt);
      return r;
    endfunction

    function void note_request(logic [1:0] op, logic [103:0] d);
      bdd_result_t r;
      r = '0;
      case (op)
        OP_MAKE:  r = run_make(d[5:0], d[15:6], d[25:16]);
        OP_EVAL:  r = run_eval(d[35:26], d[99:36]);
        OP_COUNT: r = run_count(d[35:26]);
        default:  r = '0;
      endcase
      pending = {pending, r};
    endfunction

    task report(string what, int got, int want);
      $display("mismatch on %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(logic [23:0] d, logic [1:0] st);
      bdd_result_t e;
      if (pending.size() == 0) begin
        report("unexpected result", d, 0);
        return;
      end
      e = pending.pop_front();
      if (d[9:0] != e.node_id) report("node_id", d[9:0], e.node_id);
      if (d[10] != e.value) report("value", d[10], e.value);
      if (d[20:11] != e.live_count) report("live_count", d[20:11], e.live_count);
      if (d[23:21] != 3'd0) report("pad", d[23:21], 0);
      if (st != e.status) report("status", st, e.status);
    endtask
  endclass

  logic clk, rst;
  logic s_tvalid, s_tready, m_tvalid, m_tready;
  logic [103:0] s_tdata;
  logic [1:0] s_tuser, m_tuser;
  logic [23:0] m_tdata;

  bdd_scoreboard sb;
  int idle_cnt;
  bit recv_hold;
  bit stim_done;

  bdd_node_store_engine u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // tvalid drops for a random gap before each send, or stays high when the gap is zero
  task automatic send_op(logic [1:0] op, logic [5:0] lv, logic [9:0] lo, logic [9:0] hi,
                         logic [9:0] root, logic [63:0] asg);
    int gap;
    gap = $urandom_range(0, 6);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= {4'd0, asg, root, hi, lo, lv};
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, {4'd0, asg, root, hi, lo, lv});
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [9:0] pick_id();
    int unsigned r;
    r = $urandom_range(0, 15);
    if (r == 0) return 10'($urandom_range(0, 1023));
    if (r < 4) return 10'($urandom_range(0, 1));
    return 10'($urandom_range(0, sb.used - 1));
  endfunction

  task automatic random_ops(int n, int maxlvl);
    int unsigned k;
    logic [9:0] a, b;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 19);
      a = pick_id();
      b = pick_id();
      if (k < 11)
        send_op(OP_MAKE, 6'($urandom_range(0, maxlvl)), a, b, 10'($urandom),
                {$urandom, $urandom});
      else if (k < 16)
        send_op(OP_EVAL, 6'($urandom), 10'($urandom), 10'($urandom), pick_id(),
                {$urandom, $urandom});
      else if (k < 19)
        send_op(OP_COUNT, 6'($urandom), 10'($urandom), 10'($urandom), pick_id(),
                {$urandom, $urandom});
      else
        send_op(2'd3, 6'($urandom), 10'($urandom), 10'($urandom), 10'($urandom),
                {$urandom, $urandom});
    end
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    stim_done = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: terminals, unallocated ids, equal children, duplicates, extremes
    send_op(OP_EVAL, 0, 0, 0, 0, '0);
    send_op(OP_EVAL, 0, 0, 0, 1, '1);
    send_op(OP_EVAL, 0, 0, 0, 2, '0);
    send_op(OP_COUNT, 0, 0, 0, 1, '0);
    send_op(OP_COUNT, 0, 0, 0, 1023, '0);
    send_op(OP_MAKE, 63, 1023, 0, 0, '0);
    send_op(OP_MAKE, 5, 1, 1, 0, '0);
    send_op(OP_MAKE, 63, 0, 1, 0, '0);
    send_op(OP_MAKE, 63, 0, 1, 0, '0);
    send_op(OP_MAKE, 0, 1, 0, 0, '0);
    send_op(OP_MAKE, 10, 2, 3, 0, '0);
    send_op(OP_MAKE, 10, 3, 3, 0, '0);
    send_op(OP_EVAL, 0, 0, 0, 4, 64'h8000_0000_0000_0400);
    send_op(OP_EVAL, 0, 0, 0, 4, 64'h0000_0000_0000_0001);
    send_op(OP_EVAL, 0, 0, 0, 4, '1);
    send_op(OP_COUNT, 0, 0, 0, 4, '0);
    send_op(OP_COUNT, 0, 0, 0, 2, '0);
    send_op(2'd3, 63, 1023, 1023, 1023, '1);
    send_op(OP_EVAL, 0, 0, 0, 5, '0);
    wait_drained();
    random_ops(300, 63);
    // sender pause until all results are back
    wait_drained();
    repeat (20) @(posedge clk);
    recv_hold = 1;
    random_ops(30, 63);
    random_ops(500, 7);
    // fill the store to capacity to reach the full case
    while (sb.used < NODES)
      send_op(OP_MAKE, 6'($urandom_range(0, 63)), 10'($urandom_range(0, sb.used - 1)),
              10'($urandom_range(0, sb.used - 1)), 0, '0);
    random_ops(600, 63);
    wait_drained();
    repeat (3000) @(posedge clk);
    stim_done = 1;
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  initial begin
    recv_hold = 0;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (recv_hold) begin
        m_tready <= 1'b0;
        repeat (3000) @(posedge clk);
        recv_hold = 0;
      end
      if ($urandom_range(0, 3) == 0) begin
        m_tready <= 1'b1;
        @(posedge clk);
      end else begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
    if (!stim_done && idle_cnt > WDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end
endmodule
`default_nettype wire

/* bdd_node_store_engine.f */
+incdir+sv
sv/bnse_pkg.sv
sv/bnse_ram.sv
sv/bdd_node_store_engine.sv
tb/sv/bdd_node_store_engine_tb.sv
